// File: src/assert_macros.svh
// Assertion macros shared by the RTL. They compile to nothing for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: expression does not hold");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: consequent missing one cycle later");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/stt_pkg.sv
package stt_pkg;

    localparam int MAX_TERMS = 64;
    localparam int MAX_COLS  = 64;

    localparam int ROW_W = 6;
    localparam int COL_W = 6;
    localparam int VAL_W = 32;
    localparam int CFG_W = 7;

    localparam int TERM_AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int CNT_W   = $clog2(MAX_TERMS + 1);

    localparam logic [CFG_W-1:0] NUM_COLS_RESET = CFG_W'(64);

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_term;

    typedef struct packed {
        logic              clear;
        logic              rd;
        logic [COL_AW-1:0] rd_addr;
        logic              wr;
        logic [COL_AW-1:0] wr_addr;
        logic [CNT_W-1:0]  wdata;
    } t_cnt_ctl;

endpackage

// File: src/stt_col_count.sv
// Per-column term counters. Entries without a valid bit read as zero, so a
// single-cycle clear of the valid bits empties the whole table.
module stt_col_count (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  stt_pkg::t_cnt_ctl        i_ctl,
    output logic [stt_pkg::CNT_W-1:0] o_rd_data
);

    logic [stt_pkg::CNT_W-1:0]    r_mem [stt_pkg::MAX_COLS];
    logic [stt_pkg::MAX_COLS-1:0] r_vld;
    logic [stt_pkg::CNT_W-1:0]    r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.clear) begin
            r_vld <= '0;
        end else if (i_ctl.wr) begin
            r_vld[i_ctl.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_ctl.wr_addr] <= i_ctl.wdata;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_vld[i_ctl.rd_addr] ? r_mem[i_ctl.rd_addr] : '0;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/sparse_triple_transpose.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+------------------------------------
// in        | input     | i_in_valid / o_in_stall    | i_in_row, i_in_col, i_in_value,
//           |           |                            | i_in_last
// out       | output    | o_out_valid / i_out_stall  | o_out_row, o_out_col, o_out_value,
//           |           |                            | o_out_last, o_dropped
// cfg       | input     | i_cfg_valid / o_cfg_ready  | i_cfg_data (num_cols)
//
// A stored term takes a term write, then a read-modify-write of its column
// counter; a dropped term takes only the idle state. The closing request then
// runs the prefix pass over the counter memory, the scatter of each stored term
// (term read, start read, result and start write) and the drain of the results,
// one at a time and held by any output stall. A new term is taken only once the
// previous one is through.
// Reset is synchronous and active low; it clears the sequencer, the term count,
// the drop flag, the counter valid bits and the column register (to 64).
// o_in_stall is high whenever the sequencer is away from idle, including while a
// result waits on i_out_stall; a stalled result holds its payload unchanged.
module sparse_triple_transpose (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [stt_pkg::ROW_W-1:0]       i_in_row,
    input  logic [stt_pkg::COL_W-1:0]       i_in_col,
    input  logic signed [stt_pkg::VAL_W-1:0] i_in_value,
    input  logic                            i_in_last,

    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [stt_pkg::ROW_W-1:0]       o_out_row,
    output logic [stt_pkg::COL_W-1:0]       o_out_col,
    output logic signed [stt_pkg::VAL_W-1:0] o_out_value,
    output logic                            o_out_last,
    output logic                            o_dropped,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [stt_pkg::CFG_W-1:0]       i_cfg_data
);

`include "assert_macros.svh"

    // The sequencer walks three passes once the last request arrives: a prefix
    // sum over the column counters, a scatter of the stored terms into the
    // result memory, and the drain of the result memory to the output.
    typedef enum logic [3:0] {
        S_IDLE,
        S_INC,
        S_PRE_RD,
        S_PRE_WR,
        S_SC_TERM,
        S_SC_START,
        S_SC_WR,
        S_OUT_RD,
        S_OUT_WAIT
    } t_state;

    t_state                          r_state;
    logic [stt_pkg::CFG_W-1:0]       r_num_cols;
    logic [stt_pkg::CNT_W-1:0]       r_term_count;
    logic                            r_drop;
    logic                            r_last;
    logic [stt_pkg::COL_AW-1:0]      r_col;
    logic [stt_pkg::COL_AW-1:0]      r_cidx;
    logic [stt_pkg::CNT_W-1:0]       r_pos;
    logic [stt_pkg::TERM_AW-1:0]     r_tidx;
    logic                            r_out_valid;
    logic                            r_out_last;
    logic                            r_out_dropped;

    // Memories and their registered read data.
    stt_pkg::t_term                  r_term_mem  [stt_pkg::MAX_TERMS];
    stt_pkg::t_term                  r_term_rd;
    logic [stt_pkg::CNT_W-1:0]       r_start_mem [stt_pkg::MAX_COLS];
    logic [stt_pkg::CNT_W-1:0]       r_start_rd;
    stt_pkg::t_term                  r_res_mem   [stt_pkg::MAX_TERMS];
    stt_pkg::t_term                  r_res_rd;

    logic                            w_in_acc;
    logic                            w_out_acc;
    logic                            w_keep;
    logic                            w_last_idx;
    logic [stt_pkg::COL_AW-1:0]      w_tcol;
    logic [stt_pkg::CNT_W-1:0]       w_cnt_rd;
    stt_pkg::t_cnt_ctl               w_cnt_ctl;

    logic                            w_start_we;
    logic [stt_pkg::COL_AW-1:0]      w_start_waddr;
    logic [stt_pkg::CNT_W-1:0]       w_start_wdata;

    // The block takes a request only in idle; a result is offered from a
    // register, so o_out_valid never looks at i_out_stall.
    assign w_in_acc  = i_in_valid && (r_state == S_IDLE);
    assign w_out_acc = r_out_valid && !i_out_stall;

    // A term is kept when the store has room and its column lies below both
    // the configured column count and the physical column limit.
    assign w_keep = (r_term_count < stt_pkg::CNT_W'(stt_pkg::MAX_TERMS))
                 && (32'(i_in_col) < 32'(r_num_cols))
                 && (32'(i_in_col) < 32'(stt_pkg::MAX_COLS));

    assign w_last_idx = ((stt_pkg::CNT_W'(r_tidx) + stt_pkg::CNT_W'(1)) == r_term_count);
    assign w_tcol     = stt_pkg::COL_AW'(r_term_rd.col);

    // Column counter control: incremented while loading, read by the prefix
    // pass, and wiped once the matrix is finished.
    always_comb begin
        w_cnt_ctl.clear   = (r_state == S_OUT_WAIT && w_out_acc && r_out_last)
                         || (w_in_acc && !w_keep && i_in_last
                             && r_term_count == '0);
        w_cnt_ctl.rd      = (w_in_acc && w_keep) || (r_state == S_PRE_RD);
        w_cnt_ctl.rd_addr = (r_state == S_PRE_RD) ? r_cidx
                                                  : stt_pkg::COL_AW'(i_in_col);
        w_cnt_ctl.wr      = (r_state == S_INC);
        w_cnt_ctl.wr_addr = r_col;
        w_cnt_ctl.wdata   = w_cnt_rd + stt_pkg::CNT_W'(1);
    end

    stt_col_count u_col_count (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_cnt_ctl),
        .o_rd_data (w_cnt_rd)
    );

    // The start table is written by the prefix pass with each column's first
    // slot, and bumped by the scatter every time a term of that column lands.
    always_comb begin
        w_start_we    = 1'b0;
        w_start_waddr = r_cidx;
        w_start_wdata = r_pos;
        if (r_state == S_PRE_WR) begin
            w_start_we = 1'b1;
        end else if (r_state == S_SC_WR) begin
            w_start_we    = 1'b1;
            w_start_waddr = w_tcol;
            w_start_wdata = r_start_rd + stt_pkg::CNT_W'(1);
        end
    end

    // Term store: written at the fill count, read in arrival order by the scatter.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_keep) begin
            r_term_mem[r_term_count[stt_pkg::TERM_AW-1:0]] <= '{
                row:   i_in_row,
                col:   i_in_col,
                value: i_in_value
            };
        end
        if (r_state == S_SC_TERM) begin
            r_term_rd <= r_term_mem[r_tidx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start_we) begin
            r_start_mem[w_start_waddr] <= w_start_wdata;
        end
        if (r_state == S_SC_START) begin
            r_start_rd <= r_start_mem[w_tcol];
        end
    end

    // Result store holds the transposed triples; its read register doubles as
    // the output payload register and holds still while the output stalls.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SC_WR) begin
            r_res_mem[r_start_rd[stt_pkg::TERM_AW-1:0]] <= '{
                row:   r_term_rd.col,
                col:   r_term_rd.row,
                value: r_term_rd.value
            };
        end
        if (r_state == S_OUT_RD) begin
            r_res_rd <= r_res_mem[r_tidx];
        end
    end

    // Sequencer with the registered output flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_num_cols    <= stt_pkg::NUM_COLS_RESET;
            r_term_count  <= '0;
            r_drop        <= 1'b0;
            r_last        <= 1'b0;
            r_col         <= '0;
            r_cidx        <= '0;
            r_pos         <= '0;
            r_tidx        <= '0;
            r_out_valid   <= 1'b0;
            r_out_last    <= 1'b0;
            r_out_dropped <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_num_cols <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_col  <= stt_pkg::COL_AW'(i_in_col);
                        r_last <= i_in_last;
                        r_cidx <= '0;
                        r_pos  <= '0;
                        if (w_keep) begin
                            r_term_count <= r_term_count + stt_pkg::CNT_W'(1);
                            r_state      <= S_INC;
                        end else if (i_in_last && r_term_count == '0) begin
                            // An empty matrix closes with no results at all.
                            r_drop <= 1'b0;
                        end else if (i_in_last) begin
                            r_drop  <= 1'b1;
                            r_state <= S_PRE_RD;
                        end else begin
                            r_drop <= 1'b1;
                        end
                    end
                end
                S_INC: begin
                    r_state <= r_last ? S_PRE_RD : S_IDLE;
                end
                S_PRE_RD: begin
                    r_state <= S_PRE_WR;
                end
                S_PRE_WR: begin
                    r_pos <= r_pos + w_cnt_rd;
                    if (r_cidx == stt_pkg::COL_AW'(stt_pkg::MAX_COLS - 1)) begin
                        r_tidx  <= '0;
                        r_state <= S_SC_TERM;
                    end else begin
                        r_cidx  <= r_cidx + stt_pkg::COL_AW'(1);
                        r_state <= S_PRE_RD;
                    end
                end
                S_SC_TERM: begin
                    r_state <= S_SC_START;
                end
                S_SC_START: begin
                    r_state <= S_SC_WR;
                end
                S_SC_WR: begin
                    if (w_last_idx) begin
                        r_tidx  <= '0;
                        r_state <= S_OUT_RD;
                    end else begin
                        r_tidx  <= r_tidx + stt_pkg::TERM_AW'(1);
                        r_state <= S_SC_TERM;
                    end
                end
                S_OUT_RD: begin
                    r_out_valid   <= 1'b1;
                    r_out_last    <= w_last_idx;
                    r_out_dropped <= r_drop;
                    r_state       <= S_OUT_WAIT;
                end
                S_OUT_WAIT: begin
                    if (w_out_acc) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_term_count <= '0;
                            r_drop       <= 1'b0;
                            r_state      <= S_IDLE;
                        end else begin
                            r_tidx  <= r_tidx + stt_pkg::TERM_AW'(1);
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_res_rd.row;
    assign o_out_col   = r_res_rd.col;
    assign o_out_value = r_res_rd.value;
    assign o_out_last  = r_out_last;
    assign o_dropped   = r_out_dropped;

    // A result is never offered while a new request could be taken.
    `ASSERT_ALWAYS(a_out_blocks_in, i_clk, i_rst_n, !(o_out_valid && !o_in_stall))

    // The fill count never passes the store depth.
    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_term_count <= stt_pkg::CNT_W'(stt_pkg::MAX_TERMS))

    // Every scattered term lands inside the part of the result store in use.
    `ASSERT_ALWAYS(a_slot_in_range, i_clk, i_rst_n, (r_state != S_SC_WR) || (r_start_rd < r_term_count))

    // Taking the last result empties the matrix and reopens the input.
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, w_out_acc && r_out_last, (r_term_count == '0) && !o_in_stall && !r_drop)

endmodule
